/* rtl/plir_pkg.sv */
// Shared types, command and status codes for the point list unit.
package plir_pkg;

    localparam int DEF_CAPACITY = 64;

    // Command codes
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_GET    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Cell row operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic        [2:0]  command;
        logic        [6:0]  position;
        logic signed [15:0] coord_x_in;
        logic signed [15:0] coord_y_in;
    } t_in_req;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [15:0] coord_x_out;
        logic signed [15:0] coord_y_out;
        logic        [6:0]  entry_count;
    } t_out_res;

endpackage

/* rtl/plir_cell.sv */
// One list entry cell: holds a point and trades it with its neighbors.
module plir_cell import plir_pkg::*; #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic [1:0]    i_op,
    input  logic [IW-1:0] i_idx,
    input  logic          i_rd_en,
    input  logic [31:0]   i_new,
    input  logic [31:0]   i_left,
    input  logic [31:0]   i_right,
    output logic [31:0]   o_data,
    output logic [31:0]   o_rd_data
);

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic        w_hit;
    logic        w_above;

    assign w_hit   = (i_idx == IW'(IDX));
    assign w_above = (i_idx < IW'(IDX));

    always_comb begin
        n_data = r_data;
        case (i_op)
            OP_WRITE: begin
                if (w_hit) n_data = i_new;
            end
            OP_INSERT: begin
                if (w_hit) n_data = i_new;
                else if (w_above) n_data = i_left;
            end
            OP_REMOVE: begin
                if (w_hit || w_above) n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    // Present the held point only when this cell is the one addressed
    assign o_rd_data = (i_rd_en && w_hit) ? r_data : 32'd0;

endmodule

/* rtl/point_list_insert_remove_unit.sv */
// Ordered point list built from a row of entry cells; top level.
// A command's result is registered and shows with o_valid in the cycle after it is accepted.
// Throughput: one command per cycle; the whole cell row shifts at once.
// busy stays low, so the unit takes a new request at every edge that start is high.
// Reset (synchronous, active low) empties the list and drops any pending result;
// cell contents are not cleared and are only read after being written.
module point_list_insert_remove_unit import plir_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_req  i_req,
    output t_out_res o_res,
    output logic     o_valid
);

    // Index width into the cell row, count width, and a compare width
    // wide enough for both the 7-bit position and the count plus one.
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 7) ? CW : 7) + 1;

    logic [CW-1:0] r_len;
    logic [CW-1:0] n_len;
    t_out_res      r_res;
    logic          r_valid;

    logic          w_acc;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_len;
    logic [PW-1:0] w_pos_m1;
    logic          w_full;
    logic          w_bad_ins;
    logic          w_bad_rd;

    logic [1:0]    w_op;
    logic [IW-1:0] w_idx;
    logic          w_rd_en;
    logic [1:0]    w_status;
    logic [31:0]   w_new;
    logic [31:0]   w_rd;
    logic [CW+6:0] w_cnt_ext;

    logic [31:0]   w_data [CAPACITY];
    logic [31:0]   w_rd_part [CAPACITY];

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    assign w_pos     = PW'(i_req.position);
    assign w_len     = PW'(r_len);
    assign w_pos_m1  = w_pos - PW'(1);
    assign w_full    = (r_len == CW'(CAPACITY));
    assign w_bad_ins = (w_pos == '0) || (w_pos > (w_len + PW'(1)));
    assign w_bad_rd  = (w_pos == '0) || (w_pos > w_len);
    assign w_new     = {i_req.coord_y_in, i_req.coord_x_in};

    // Decode the request into one row operation, a target cell and a status
    always_comb begin
        w_op     = OP_NONE;
        w_idx    = w_pos_m1[IW-1:0];
        w_rd_en  = 1'b0;
        w_status = ST_OK;
        n_len    = r_len;
        if (w_acc) begin
            case (i_req.command)
                CMD_PUSH: begin
                    w_idx = r_len[IW-1:0];
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_op  = OP_WRITE;
                        n_len = r_len + CW'(1);
                    end
                end
                CMD_INSERT: begin
                    // Position check takes priority over the full check
                    if (w_bad_ins) begin
                        w_status = ST_BADPOS;
                    end else if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_op  = OP_INSERT;
                        n_len = r_len + CW'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (w_bad_rd) begin
                        w_status = ST_BADPOS;
                    end else begin
                        w_op    = OP_REMOVE;
                        w_rd_en = 1'b1;
                        n_len   = r_len - CW'(1);
                    end
                end
                CMD_CLEAR: begin
                    n_len = '0;
                end
                CMD_GET: begin
                    if (w_bad_rd) begin
                        w_status = ST_BADPOS;
                    end else begin
                        w_rd_en = 1'b1;
                    end
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
    end

    // Row of cells: each takes the new point, its left neighbor's or its
    // right neighbor's point according to where it sits against the target.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        plir_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_op      (w_op),
            .i_idx     (w_idx),
            .i_rd_en   (w_rd_en),
            .i_new     (w_new),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[g]),
            .o_rd_data (w_rd_part[g])
        );
    end

    // Only the addressed cell drives nonzero data, so an OR merges the row
    always_comb begin
        w_rd = 32'd0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_rd_part[k];
        end
    end

    assign w_cnt_ext = {7'd0, n_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_valid <= w_acc;
        end
    end

    // Hold the result payload for the strobe cycle
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res.status      <= w_status;
            r_res.coord_x_out <= w_rd[15:0];
            r_res.coord_y_out <= w_rd[31:16];
            r_res.entry_count <= w_cnt_ext[6:0];
        end
    end

    assign o_res   = r_res;
    assign o_valid = r_valid;

endmodule
